>>> src/mrt_pkg.sv
// Shared constants, types and helpers of the multipath route table.
package mrt_pkg;

    localparam int TABLE_SLOTS = 64;
    localparam int MAX_HOPS    = 8;
    localparam int ADDR_BITS   = 32;
    localparam int DIST_BITS   = 32;

    localparam int SLOT_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int HOP_W   = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1;
    localparam int CNT_W   = $clog2(MAX_HOPS + 1);
    localparam int HADDR_W = $clog2(TABLE_SLOTS * MAX_HOPS);

    localparam int OUT_SLOT_W = 6;
    localparam int OUT_CNT_W  = 4;
    localparam int OUT_HOP_W  = 32;

    typedef enum logic [1:0] {
        KIND_SET     = 2'd0,
        KIND_DEL_HOP = 2'd1,
        KIND_DEL_DST = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NOT_FOUND  = 2'd1,
        ST_TABLE_FULL = 2'd2,
        ST_HOP_FULL   = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DSCAN,
        OP_RESP,
        OP_FREE,
        OP_NEW,
        OP_META_LATCH,
        OP_HSCAN,
        OP_WR_DIST,
        OP_APPEND,
        OP_DEL_BEGIN,
        OP_SHIFT_RD,
        OP_SHIFT_WR,
        OP_SHIFT_FIN,
        OP_RSCAN,
        OP_FINISH
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        t_status code;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       dscan_end;
        logic       found;
        logic       free_found;
        logic       hscan_end;
        logic       hfound;
        logic       list_full;
        logic       last_hop;
        logic       shift_end;
        logic       rscan_end;
    } t_dp_status;

    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic [DIST_BITS-1:0] metric;
    } t_hop;

    function automatic logic [HADDR_W-1:0] hop_index(input logic [SLOT_W-1:0] slot,
                                                     input logic [CNT_W-1:0] idx);
        hop_index = HADDR_W'(slot) * HADDR_W'(MAX_HOPS) + HADDR_W'(idx);
    endfunction

endpackage

>>> src/mrt_ram.sv
// Generic simple dual-port RAM with registered read.
module mrt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/mrt_ctrl.sv
// Sequencing state machine of the multipath route table.
module mrt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  mrt_pkg::t_dp_status i_st,
    output mrt_pkg::t_cmd       o_cmd,
    output logic                o_busy
);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_DSCAN    = 11'b000_0000_0010,
        S_DECIDE   = 11'b000_0000_0100,
        S_META_RD  = 11'b000_0000_1000,
        S_HSCAN    = 11'b000_0001_0000,
        S_HDECIDE  = 11'b000_0010_0000,
        S_SHIFT_RD = 11'b000_0100_0000,
        S_SHIFT_WR = 11'b000_1000_0000,
        S_RSCAN    = 11'b001_0000_0000,
        S_FINISH   = 11'b010_0000_0000,
        S_SPARE    = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = mrt_pkg::OP_NONE;
        o_cmd.code = mrt_pkg::ST_OK;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = mrt_pkg::OP_LOAD;
                    n_state  = S_DSCAN;
                end
            end
            S_DSCAN: begin
                o_cmd.op = mrt_pkg::OP_DSCAN;
                if (i_st.dscan_end) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_IDLE;
                if (i_st.kind == mrt_pkg::KIND_SET) begin
                    if (i_st.found) begin
                        n_state = S_META_RD;
                    end else if (i_st.free_found) begin
                        o_cmd.op = mrt_pkg::OP_NEW;
                    end else begin
                        o_cmd.op   = mrt_pkg::OP_RESP;
                        o_cmd.code = mrt_pkg::ST_TABLE_FULL;
                    end
                end else if (i_st.kind == mrt_pkg::KIND_DEL_HOP && i_st.found) begin
                    n_state = S_META_RD;
                end else if (i_st.kind == mrt_pkg::KIND_DEL_DST && i_st.found) begin
                    o_cmd.op = mrt_pkg::OP_FREE;
                end else begin
                    o_cmd.op   = mrt_pkg::OP_RESP;
                    o_cmd.code = mrt_pkg::ST_NOT_FOUND;
                end
            end
            S_META_RD: begin
                o_cmd.op = mrt_pkg::OP_META_LATCH;
                n_state  = S_HSCAN;
            end
            S_HSCAN: begin
                o_cmd.op = mrt_pkg::OP_HSCAN;
                if (i_st.hscan_end) begin
                    n_state = S_HDECIDE;
                end
            end
            S_HDECIDE: begin
                n_state = S_IDLE;
                if (i_st.kind == mrt_pkg::KIND_SET) begin
                    if (i_st.hfound) begin
                        o_cmd.op = mrt_pkg::OP_WR_DIST;
                        n_state  = S_RSCAN;
                    end else if (i_st.list_full) begin
                        o_cmd.op   = mrt_pkg::OP_RESP;
                        o_cmd.code = mrt_pkg::ST_HOP_FULL;
                    end else begin
                        o_cmd.op = mrt_pkg::OP_APPEND;
                        n_state  = S_RSCAN;
                    end
                end else if (!i_st.hfound) begin
                    o_cmd.op   = mrt_pkg::OP_RESP;
                    o_cmd.code = mrt_pkg::ST_NOT_FOUND;
                end else if (i_st.last_hop) begin
                    o_cmd.op = mrt_pkg::OP_FREE;
                end else begin
                    o_cmd.op = mrt_pkg::OP_DEL_BEGIN;
                    n_state  = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD: begin
                if (i_st.shift_end) begin
                    o_cmd.op = mrt_pkg::OP_SHIFT_FIN;
                    n_state  = S_RSCAN;
                end else begin
                    o_cmd.op = mrt_pkg::OP_SHIFT_RD;
                    n_state  = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.op = mrt_pkg::OP_SHIFT_WR;
                n_state  = S_SHIFT_RD;
            end
            S_RSCAN: begin
                o_cmd.op = mrt_pkg::OP_RSCAN;
                if (i_st.rscan_end) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.op = mrt_pkg::OP_FINISH;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

>>> src/mrt_dp.sv
// Datapath of the multipath route table: stores, scan counters and result registers.
module mrt_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mrt_pkg::t_cmd         i_cmd,
    input  logic [1:0]            i_kind,
    input  logic [31:0]           i_dst_addr,
    input  logic [31:0]           i_hop_addr,
    input  logic [31:0]           i_distance,
    output mrt_pkg::t_dp_status   o_st,
    output logic                  o_done,
    output logic [1:0]            o_status,
    output logic [5:0]            o_slot,
    output logic [3:0]            o_hop_count,
    output logic [31:0]           o_best_hop,
    output logic [31:0]           o_best_distance
);

    localparam int SW = mrt_pkg::SLOT_W;
    localparam int HW = mrt_pkg::HOP_W;
    localparam int CW = mrt_pkg::CNT_W;
    localparam int AB = mrt_pkg::ADDR_BITS;
    localparam int DB = mrt_pkg::DIST_BITS;

    // Request latched at acceptance.
    logic [1:0]          r_kind;
    logic [AB-1:0]       r_dst;
    logic [AB-1:0]       r_hop;
    logic [DB-1:0]       r_dist;

    logic [mrt_pkg::TABLE_SLOTS-1:0] r_valid;

    logic [SW:0]         r_sidx;
    logic [SW-1:0]       r_sq;
    logic [SW-1:0]       r_slot;
    logic [SW-1:0]       r_free;
    logic                r_found;
    logic                r_free_found;
    logic                r_pend;

    logic [CW-1:0]       r_n;
    logic [CW-1:0]       r_hidx;
    logic [HW-1:0]       r_hq;
    logic [HW-1:0]       r_h;
    logic                r_hfound;

    logic [DB-1:0]       r_least;
    logic [AB-1:0]       r_best_addr;

    logic                r_done;
    logic [1:0]          r_status;
    logic [5:0]          r_oslot;
    logic [3:0]          r_ocnt;
    logic [31:0]         r_obest;
    logic [31:0]         r_odist;

    // Store ports.
    logic                        key_we;
    logic [SW-1:0]               key_waddr;
    logic [AB-1:0]               key_rd;
    logic                        meta_we;
    logic [SW-1:0]               meta_waddr;
    logic [CW-1:0]               meta_wdata;
    logic [CW-1:0]               meta_rd;
    logic                        hop_we;
    logic [mrt_pkg::HADDR_W-1:0] hop_waddr;
    logic [mrt_pkg::HADDR_W-1:0] hop_raddr;
    mrt_pkg::t_hop               hop_wdata;
    mrt_pkg::t_hop               hop_rd;

    logic                dmatch;
    logic                hmatch;
    logic                last_q;
    logic [CW-1:0]       hidx_inc;
    logic                hissue;

    assign dmatch   = r_valid[r_sq] && (key_rd == r_dst);
    assign hmatch   = (hop_rd.addr == r_hop);
    assign last_q   = (CW'(r_hq) == r_n - CW'(1));
    assign hidx_inc = r_hidx + CW'(1);
    assign hissue   = (r_hidx < r_n);

    always_comb begin
        key_we     = 1'b0;
        key_waddr  = r_free;
        meta_we    = 1'b0;
        meta_waddr = r_slot;
        meta_wdata = r_n;
        hop_we     = 1'b0;
        hop_waddr  = mrt_pkg::hop_index(r_slot, r_hidx);
        hop_wdata  = '{addr: r_hop, metric: r_dist};
        hop_raddr  = mrt_pkg::hop_index(r_slot, r_hidx);
        case (i_cmd.op)
            mrt_pkg::OP_NEW: begin
                key_we     = 1'b1;
                meta_we    = 1'b1;
                meta_waddr = r_free;
                meta_wdata = CW'(1);
                hop_we     = 1'b1;
                hop_waddr  = mrt_pkg::hop_index(r_free, CW'(0));
            end
            mrt_pkg::OP_WR_DIST: begin
                hop_we    = 1'b1;
                hop_waddr = mrt_pkg::hop_index(r_slot, CW'(r_h));
            end
            mrt_pkg::OP_APPEND: begin
                hop_we    = 1'b1;
                hop_waddr = mrt_pkg::hop_index(r_slot, r_n);
            end
            mrt_pkg::OP_SHIFT_RD: begin
                hop_raddr = mrt_pkg::hop_index(r_slot, hidx_inc);
            end
            mrt_pkg::OP_SHIFT_WR: begin
                hop_we    = 1'b1;
                hop_wdata = hop_rd;
            end
            mrt_pkg::OP_FINISH: begin
                meta_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    mrt_ram #(.WIDTH(AB), .DEPTH(mrt_pkg::TABLE_SLOTS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (r_dst),
        .i_raddr (r_sidx[SW-1:0]),
        .o_rdata (key_rd)
    );

    mrt_ram #(.WIDTH(CW), .DEPTH(mrt_pkg::TABLE_SLOTS)) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (meta_waddr),
        .i_wdata (meta_wdata),
        .i_raddr (r_slot),
        .o_rdata (meta_rd)
    );

    mrt_ram #(.WIDTH($bits(mrt_pkg::t_hop)),
              .DEPTH(mrt_pkg::TABLE_SLOTS * mrt_pkg::MAX_HOPS)) u_hop_ram (
        .i_clk   (i_clk),
        .i_we    (hop_we),
        .i_waddr (hop_waddr),
        .i_wdata (hop_wdata),
        .i_raddr (hop_raddr),
        .o_rdata (hop_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_done  <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (i_cmd.op)
                mrt_pkg::OP_LOAD: begin
                    r_kind       <= i_kind;
                    r_dst        <= i_dst_addr[AB-1:0];
                    r_hop        <= i_hop_addr[AB-1:0];
                    r_dist       <= i_distance;
                    r_sidx       <= '0;
                    r_pend       <= 1'b0;
                    r_found      <= 1'b0;
                    r_free_found <= 1'b0;
                end
                mrt_pkg::OP_DSCAN: begin
                    if (r_sidx < (SW + 1)'(mrt_pkg::TABLE_SLOTS)) begin
                        r_sidx <= r_sidx + (SW + 1)'(1);
                        r_sq   <= r_sidx[SW-1:0];
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (r_pend) begin
                        if (dmatch) begin
                            r_found <= 1'b1;
                            r_slot  <= r_sq;
                        end
                        // Lowest free slot, in case the destination is new.
                        if (!r_valid[r_sq] && !r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free       <= r_sq;
                        end
                    end
                end
                mrt_pkg::OP_RESP: begin
                    r_done   <= 1'b1;
                    r_status <= i_cmd.code;
                    r_oslot  <= '0;
                    r_ocnt   <= '0;
                    r_obest  <= '0;
                    r_odist  <= '0;
                end
                mrt_pkg::OP_FREE: begin
                    r_valid[r_slot] <= 1'b0;
                    r_done   <= 1'b1;
                    r_status <= mrt_pkg::ST_OK;
                    r_oslot  <= mrt_pkg::OUT_SLOT_W'(r_slot);
                    r_ocnt   <= '0;
                    r_obest  <= '0;
                    r_odist  <= '0;
                end
                mrt_pkg::OP_NEW: begin
                    r_valid[r_free] <= 1'b1;
                    r_done   <= 1'b1;
                    r_status <= mrt_pkg::ST_OK;
                    r_oslot  <= mrt_pkg::OUT_SLOT_W'(r_free);
                    r_ocnt   <= mrt_pkg::OUT_CNT_W'(1);
                    r_obest  <= mrt_pkg::OUT_HOP_W'(r_hop);
                    r_odist  <= r_dist;
                end
                mrt_pkg::OP_META_LATCH: begin
                    r_n      <= meta_rd;
                    r_hidx   <= '0;
                    r_pend   <= 1'b0;
                    r_hfound <= 1'b0;
                end
                mrt_pkg::OP_HSCAN: begin
                    if (hissue) begin
                        r_hidx <= hidx_inc;
                        r_hq   <= r_hidx[HW-1:0];
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (r_pend && hmatch) begin
                        r_hfound <= 1'b1;
                        r_h      <= r_hq;
                    end
                end
                mrt_pkg::OP_WR_DIST: begin
                    r_hidx <= '0;
                    r_pend <= 1'b0;
                end
                mrt_pkg::OP_APPEND: begin
                    r_n    <= r_n + CW'(1);
                    r_hidx <= '0;
                    r_pend <= 1'b0;
                end
                mrt_pkg::OP_DEL_BEGIN: begin
                    r_hidx <= CW'(r_h);
                end
                mrt_pkg::OP_SHIFT_WR: begin
                    r_hidx <= hidx_inc;
                end
                mrt_pkg::OP_SHIFT_FIN: begin
                    r_n    <= r_n - CW'(1);
                    r_hidx <= '0;
                    r_pend <= 1'b0;
                end
                mrt_pkg::OP_RSCAN: begin
                    if (hissue) begin
                        r_hidx <= hidx_inc;
                        r_hq   <= r_hidx[HW-1:0];
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                    // Strict compare keeps the first hop on ties.
                    if (r_pend && (r_hq == '0 || hop_rd.metric < r_least)) begin
                        r_least     <= hop_rd.metric;
                        r_best_addr <= hop_rd.addr;
                    end
                end
                mrt_pkg::OP_FINISH: begin
                    r_done   <= 1'b1;
                    r_status <= mrt_pkg::ST_OK;
                    r_oslot  <= mrt_pkg::OUT_SLOT_W'(r_slot);
                    r_ocnt   <= mrt_pkg::OUT_CNT_W'(r_n);
                    r_obest  <= mrt_pkg::OUT_HOP_W'(r_best_addr);
                    r_odist  <= r_least;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_st.kind       = r_kind;
        o_st.dscan_end  = r_pend && (dmatch ||
                          r_sq == SW'(mrt_pkg::TABLE_SLOTS - 1));
        o_st.found      = r_found;
        o_st.free_found = r_free_found;
        o_st.hscan_end  = r_pend && (hmatch || last_q);
        o_st.hfound     = r_hfound;
        o_st.list_full  = (r_n >= CW'(mrt_pkg::MAX_HOPS));
        o_st.last_hop   = (r_n <= CW'(1));
        o_st.shift_end  = !(hidx_inc < r_n);
        o_st.rscan_end  = r_pend && last_q;
    end

    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_slot          = r_oslot;
    assign o_hop_count     = r_ocnt;
    assign o_best_hop      = r_obest;
    assign o_best_distance = r_odist;

endmodule

>>> src/multipath_route_table_top.sv
// Run time grows with the slot position reached by the key sweep (up to 64), with the
// hop search and rescan over the n hops of the list, and with each hop closed up by a
// delete.
// One transaction is in flight at a time; busy stays high until the result strobe
// is set up, and o_done lasts exactly one cycle. The key sweep reads one slot a cycle.
// Synchronous active-low reset empties the table and clears busy and o_done.
module multipath_route_table_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_dst_addr,
    input  logic [31:0] i_hop_addr,
    input  logic [31:0] i_distance,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [5:0]  o_slot,
    output logic [3:0]  o_hop_count,
    output logic [31:0] o_best_hop,
    output logic [31:0] o_best_distance
);

    mrt_pkg::t_cmd       cmd;
    mrt_pkg::t_dp_status st;

    mrt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_st    (st),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    mrt_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_kind          (i_kind),
        .i_dst_addr      (i_dst_addr),
        .i_hop_addr      (i_hop_addr),
        .i_distance      (i_distance),
        .o_st            (st),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_slot          (o_slot),
        .o_hop_count     (o_hop_count),
        .o_best_hop      (o_best_hop),
        .o_best_distance (o_best_distance)
    );

endmodule

>>> src/mrt_checker.sv
// Port-level checks of the multipath route table, bound to the top level.
module mrt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [1:0]  o_status,
    input logic [5:0]  o_slot,
    input logic [3:0]  o_hop_count,
    input logic [31:0] o_best_hop,
    input logic [31:0] o_best_distance
);

    // An accepted transaction always keeps the block busy for the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after an accepted transaction");

    // After a result the block returns to idle and must sweep the keys again, so strobes never come back to back.
    a_done_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe on two cycles in a row");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status != mrt_pkg::ST_OK |->
            o_slot == '0 && o_hop_count == '0 && o_best_hop == '0 && o_best_distance == '0)
        else $error("error result carries nonzero fields");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_hop_count <= 4'(mrt_pkg::MAX_HOPS))
        else $error("hop count beyond list size");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done && !busy)
        else $error("strobe or busy right after reset");

endmodule

bind multipath_route_table_top mrt_checker u_mrt_checker (.*);
